// ----- src/pl_pkg.sv -----
package pl_pkg;

  localparam int unsigned DEPTH_DEF     = 16;
  localparam int unsigned WORD_BITS_DEF = 32;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_READ   = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_NULL  = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [4:0]  position;
    logic [31:0] word_in;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] word_out;
    logic [4:0]  entries;
  } rsp_t;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

// ----- src/pl_ram.sv -----
module pl_ram #(
  parameter int unsigned DEPTH     = pl_pkg::DEPTH_DEF,
  parameter int unsigned WORD_BITS = pl_pkg::WORD_BITS_DEF,
  localparam int unsigned IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk_i,
  input  pl_pkg::mem_ctl_t     ctl_i,
  input  logic [IDX_W-1:0]     waddr_i,
  input  logic [WORD_BITS-1:0] wdata_i,
  input  logic [IDX_W-1:0]     raddr_i,
  output logic [WORD_BITS-1:0] rdata_o
);

  logic [WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.re) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- src/pl_seq.sv -----
module pl_seq #(
  parameter int unsigned DEPTH     = pl_pkg::DEPTH_DEF,
  parameter int unsigned WORD_BITS = pl_pkg::WORD_BITS_DEF,
  localparam int unsigned IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNT_W    = $clog2(DEPTH + 1),
  localparam int unsigned CMP_W    = (CNT_W > 5) ? CNT_W : 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  input  pl_pkg::req_t         req_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output pl_pkg::rsp_t         res_o,
  output pl_pkg::mem_ctl_t     mem_ctl_o,
  output logic [IDX_W-1:0]     mem_waddr_o,
  output logic [WORD_BITS-1:0] mem_wdata_o,
  output logic [IDX_W-1:0]     mem_raddr_o,
  input  logic [WORD_BITS-1:0] mem_rdata_i
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_RD_WAIT  = 3'd1;
  localparam logic [2:0] S_INS_MOVE = 3'd2;
  localparam logic [2:0] S_INS_LAST = 3'd3;
  localparam logic [2:0] S_REM_HEAD = 3'd4;
  localparam logic [2:0] S_REM_MOVE = 3'd5;
  localparam logic [2:0] S_DONE     = 3'd6;

  logic [2:0]           state_q, state_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [4:0]           pos_q, pos_d;
  logic [WORD_BITS-1:0] word_q, word_d;
  logic [1:0]           status_q, status_d;
  logic [WORD_BITS-1:0] res_word_q, res_word_d;

  logic [CMP_W-1:0]     pos_ext, cnt_ext;
  logic [WORD_BITS-1:0] word_in_w;
  logic                 more_left;

  assign pos_ext   = CMP_W'(req_i.position);
  assign cnt_ext   = CMP_W'(cnt_q);
  assign word_in_w = WORD_BITS'(req_i.word_in);
  assign more_left = (CNT_W'(idx_q) + CNT_W'(1)) < cnt_q;

  assign req_ready_o    = (state_q == S_IDLE);
  assign res_valid_o    = (state_q == S_DONE);
  assign res_o.status   = status_q;
  assign res_o.word_out = 32'(res_word_q);
  assign res_o.entries  = 5'(cnt_q);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    word_d      = word_q;
    status_d    = status_q;
    res_word_d  = res_word_q;
    mem_ctl_o   = '0;
    mem_waddr_o = '0;
    mem_wdata_o = mem_rdata_i;
    mem_raddr_o = '0;

    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          pos_d      = req_i.position;
          word_d     = word_in_w;
          status_d   = pl_pkg::ST_OK;
          res_word_d = '0;
          state_d    = S_DONE;
          case (req_i.action)
            pl_pkg::ACT_INSERT: begin
              if (pos_ext > cnt_ext) begin
                status_d = pl_pkg::ST_RANGE;
              end else if (cnt_q == CNT_W'(DEPTH)) begin
                status_d = pl_pkg::ST_FULL;
              end else if (word_in_w == '0) begin
                status_d = pl_pkg::ST_NULL;
              end else if (pos_ext == cnt_ext) begin
                state_d = S_INS_LAST;
              end else begin
                // start from the tail: fetch the last entry
                mem_ctl_o.re = 1'b1;
                mem_raddr_o  = IDX_W'(cnt_q - CNT_W'(1));
                idx_d        = IDX_W'(cnt_q - CNT_W'(1));
                state_d      = S_INS_MOVE;
              end
            end
            pl_pkg::ACT_READ: begin
              if (pos_ext >= cnt_ext) begin
                status_d = pl_pkg::ST_RANGE;
              end else begin
                mem_ctl_o.re = 1'b1;
                mem_raddr_o  = IDX_W'(req_i.position);
                state_d      = S_RD_WAIT;
              end
            end
            pl_pkg::ACT_REMOVE: begin
              if (pos_ext >= cnt_ext) begin
                status_d = pl_pkg::ST_RANGE;
              end else begin
                mem_ctl_o.re = 1'b1;
                mem_raddr_o  = IDX_W'(req_i.position);
                idx_d        = IDX_W'(req_i.position);
                state_d      = S_REM_HEAD;
              end
            end
            default: begin
              status_d = pl_pkg::ST_OK;
            end
          endcase
        end
      end
      S_RD_WAIT: begin
        res_word_d = mem_rdata_i;
        state_d    = S_DONE;
      end
      S_INS_MOVE: begin
        // write fetched entry one place toward the tail
        mem_ctl_o.we = 1'b1;
        mem_waddr_o  = IDX_W'(idx_q + IDX_W'(1));
        if (idx_q == IDX_W'(pos_q)) begin
          state_d = S_INS_LAST;
        end else begin
          mem_ctl_o.re = 1'b1;
          mem_raddr_o  = IDX_W'(idx_q - IDX_W'(1));
          idx_d        = IDX_W'(idx_q - IDX_W'(1));
        end
      end
      S_INS_LAST: begin
        mem_ctl_o.we = 1'b1;
        mem_waddr_o  = IDX_W'(pos_q);
        mem_wdata_o  = word_q;
        cnt_d        = CNT_W'(cnt_q + CNT_W'(1));
        state_d      = S_DONE;
      end
      S_REM_HEAD, S_REM_MOVE: begin
        if (state_q == S_REM_HEAD) begin
          res_word_d = mem_rdata_i;
        end else begin
          // close the gap: write fetched entry one place toward the head
          mem_ctl_o.we = 1'b1;
          mem_waddr_o  = IDX_W'(idx_q - IDX_W'(1));
        end
        if (more_left) begin
          mem_ctl_o.re = 1'b1;
          mem_raddr_o  = IDX_W'(idx_q + IDX_W'(1));
          idx_d        = IDX_W'(idx_q + IDX_W'(1));
          state_d      = S_REM_MOVE;
        end else begin
          cnt_d   = CNT_W'(cnt_q - CNT_W'(1));
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    pos_q      <= pos_d;
    word_q     <= word_d;
    status_q   <= status_d;
    res_word_q <= res_word_d;
  end

endmodule

// ----- src/positional_list.sv -----
// Channel  Direction  Signals                             Struct
// -------  ---------  ----------------------------------  -------------
// in       input      in_valid_i, in_ready_o, in_i        pl_pkg::req_t
// out      output     out_valid_o, out_ready_i, out_o     pl_pkg::rsp_t
//
// One request at a time. An insert shifts the entries from position p up to the
// tail, a remove shifts those behind p toward the head; the single write port
// of the slot RAM moves one entry per cycle. Reset clears the entry count, the
// control state and the output valid; slot contents stay undefined until
// written. A stalled output holds its result while the next request is
// already transferred in and worked on.
module positional_list #(
  parameter int unsigned DEPTH     = pl_pkg::DEPTH_DEF,
  parameter int unsigned WORD_BITS = pl_pkg::WORD_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  pl_pkg::req_t in_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output pl_pkg::rsp_t out_o
);

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  pl_pkg::mem_ctl_t     mem_ctl;
  logic [IDX_W-1:0]     mem_waddr;
  logic [IDX_W-1:0]     mem_raddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [WORD_BITS-1:0] mem_rdata;

  logic         res_valid;
  logic         res_ready;
  pl_pkg::rsp_t res;

  logic         out_valid_q;
  pl_pkg::rsp_t out_q;

  // Slot store: the list itself, head in entry 0
  pl_ram #(
    .DEPTH    (DEPTH),
    .WORD_BITS(WORD_BITS)
  ) u_ram (
    .clk_i  (clk_i),
    .ctl_i  (mem_ctl),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // Sequencer: checks each request, then for an insert or remove shifts entries
  // through the RAM one per cycle, and counts them
  pl_seq #(
    .DEPTH    (DEPTH),
    .WORD_BITS(WORD_BITS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(in_valid_i),
    .req_ready_o(in_ready_o),
    .req_i      (in_i),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res),
    .mem_ctl_o  (mem_ctl),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

  // Output register: take a new result when empty or being drained
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // A rejected request never returns data
  a_err_word_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.status != pl_pkg::ST_OK) |-> out_o.word_out == '0)
    else $error("non-zero word on a rejected request");

  // Full is reported only with a full list
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.status == pl_pkg::ST_FULL) |-> out_o.entries == 5'(DEPTH))
    else $error("full status with list not full");

  // Sequencer never offers a result while ready for a new request
  a_idle_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !res_valid)
    else $error("result pending while idle");

  // The sequencer is never ready straight after taking a request
  a_no_same_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("sequencer ready straight after a transfer");

endmodule
